### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check cons in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// check cons in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/isc_pkg.sv
// ----------------------------------------------------------------------------
// Intertoken space classifier package
// Character codes, result codes, state and result types, and the per-byte
// classification function.
// ----------------------------------------------------------------------------
package isc_pkg;

   localparam int MAX_NEST = 255;
   localparam int NEST_W   = $clog2(MAX_NEST + 1);

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_BAR   = 8'h7C;

   localparam logic [2:0] KIND_TOKEN        = 3'd0;
   localparam logic [2:0] KIND_WHITESPACE   = 3'd1;
   localparam logic [2:0] KIND_LINE_END     = 3'd2;
   localparam logic [2:0] KIND_LINE_COMMENT = 3'd3;
   localparam logic [2:0] KIND_NEST_COMMENT = 3'd4;

   localparam logic [1:0] ERR_NONE         = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW     = 2'd1;
   localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

   typedef logic [NEST_W-1:0] nest_type;

   typedef struct packed {
      logic        in_line_comment;
      nest_type    nest_depth;
      logic        pair_second;
      logic [31:0] line_count;
   } ctx_type;

   typedef struct packed {
      logic [7:0]  char_out;
      logic [2:0]  kind;
      logic [31:0] line_number;
      logic [1:0]  error;
      logic        last;
   } result_type;

   typedef struct packed {
      ctx_type    ctx;
      result_type res;
   } step_type;

   localparam ctx_type CTX_RESET = '{
      in_line_comment: 1'b0,
      nest_depth:      '0,
      pair_second:     1'b0,
      line_count:      32'd1
   };

   function automatic step_type classify(ctx_type st, logic [7:0] b, logic has_next,
                                         logic [7:0] n, logic is_last);
      step_type   r;
      ctx_type    nx;
      logic [2:0] kind;
      logic [1:0] err;
      logic       eol;
      nx   = st;
      kind = KIND_TOKEN;
      err  = ERR_NONE;
      eol  = (b == CHAR_CR) || (b == CHAR_LF);
      if (st.pair_second) begin
         nx.pair_second = 1'b0;
         kind = (b == CHAR_LF) ? KIND_LINE_END : KIND_NEST_COMMENT;
      end else if (eol) begin
         kind = KIND_LINE_END;
         if (st.line_count != '1) begin
            nx.line_count = st.line_count + 32'd1;
         end
         nx.in_line_comment = 1'b0;
         if (b == CHAR_CR && has_next && n == CHAR_LF) begin
            nx.pair_second = 1'b1;
         end
      end else if (st.nest_depth != '0) begin
         kind = KIND_NEST_COMMENT;
         if (has_next && b == CHAR_BAR && n == CHAR_HASH) begin
            nx.nest_depth  = st.nest_depth - NEST_W'(1);
            nx.pair_second = 1'b1;
         end else if (has_next && b == CHAR_HASH && n == CHAR_BAR) begin
            if (st.nest_depth < NEST_W'(MAX_NEST)) begin
               nx.nest_depth = st.nest_depth + NEST_W'(1);
            end else begin
               err = ERR_OVERFLOW;
            end
            nx.pair_second = 1'b1;
         end
      end else if (st.in_line_comment) begin
         kind = KIND_LINE_COMMENT;
      end else if (b == CHAR_SPACE || b == CHAR_TAB) begin
         kind = KIND_WHITESPACE;
      end else if (b == CHAR_SEMI) begin
         kind = KIND_LINE_COMMENT;
         nx.in_line_comment = 1'b1;
      end else if (has_next && b == CHAR_HASH && n == CHAR_BAR) begin
         kind = KIND_NEST_COMMENT;
         nx.nest_depth  = NEST_W'(1);
         nx.pair_second = 1'b1;
      end
      if (is_last && nx.nest_depth != '0) begin
         err = ERR_UNTERMINATED;
      end
      r.ctx             = nx;
      r.res.char_out    = b;
      r.res.kind        = kind;
      r.res.line_number = nx.line_count;
      r.res.error       = err;
      r.res.last        = is_last;
      return r;
   endfunction

endpackage

### src/isc_if.sv
// ----------------------------------------------------------------------------
// Intertoken space classifier channels
// Valid/ready channels for source bytes and classification results.
// ----------------------------------------------------------------------------
interface isc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_input;

   modport source (output valid, output char_in, output end_of_input, input ready);
   modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface isc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  char_out;
   logic [2:0]  kind;
   logic [31:0] line_number;
   logic [1:0]  error;
   logic        last;

   modport source (output valid, output char_out, output kind, output line_number,
                   output error, output last, input ready);
   modport sink   (input valid, input char_out, input kind, input line_number,
                   input error, input last, output ready);
endinterface

### src/intertoken_space_classifier.sv
// ----------------------------------------------------------------------------
// Intertoken space classifier
// Classifies source bytes as token text, whitespace, line ending, line-comment
// or nested-comment text, and tracks the line number.
// ----------------------------------------------------------------------------
// One byte is taken per cycle and each byte gives one result, one transaction
// behind the input because the block holds a byte back to see the next one.
// The transaction marked end_of_input flushes the held byte, if any, and itself,
// so it gives two results when a byte is held. Results go into a three-entry
// queue; the input is ready while at most one result is queued. With the
// result side always ready this takes one byte per cycle, except that the input
// is not ready after a flush that gives two results. After the final byte the
// held byte and the context, line counter included, return to reset values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module intertoken_space_classifier (
   input  logic              clock,
   input  logic              reset,
   isc_req_if.sink           req_ch,
   isc_rsp_if.source         rsp_ch
);

   logic [7:0]           held_byte_ff, held_byte_in;
   logic                 held_valid_ff, held_valid_in;
   isc_pkg::ctx_type     ctx_ff, ctx_in;
   isc_pkg::result_type  slot_ff [3];
   isc_pkg::result_type  slot_in [3];
   logic [1:0]           count_ff, count_in;

   isc_pkg::step_type    step0, step1;
   isc_pkg::ctx_type     ctx_mid;
   isc_pkg::result_type  r0, r1;
   logic                 accept, pop;
   logic [1:0]           push_n, base;
   logic                 flush, flush_with_held, depth_ok;

   assign accept = req_ch.valid && req_ch.ready;
   assign pop    = rsp_ch.valid && rsp_ch.ready;

   assign req_ch.ready = (count_ff <= 2'd1);
   assign rsp_ch.valid = (count_ff != 2'd0);
   assign rsp_ch.char_out    = slot_ff[0].char_out;
   assign rsp_ch.kind        = slot_ff[0].kind;
   assign rsp_ch.line_number = slot_ff[0].line_number;
   assign rsp_ch.error       = slot_ff[0].error;
   assign rsp_ch.last        = slot_ff[0].last;

   always_comb begin
      step0   = isc_pkg::classify(ctx_ff, held_byte_ff, 1'b1, req_ch.char_in, 1'b0);
      ctx_mid = held_valid_ff ? step0.ctx : ctx_ff;
      step1   = isc_pkg::classify(ctx_mid, req_ch.char_in, 1'b0, 8'h00, 1'b1);
      if (held_valid_ff) begin
         r0 = step0.res;
         r1 = step1.res;
      end else begin
         r0 = step1.res;
         r1 = step1.res;
      end
      push_n = 2'd0;
      if (accept) begin
         push_n = 2'(held_valid_ff) + 2'(req_ch.end_of_input);
      end
   end

   always_comb begin
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      ctx_in        = ctx_ff;
      if (accept) begin
         if (req_ch.end_of_input) begin
            held_byte_in  = 8'h00;
            held_valid_in = 1'b0;
            ctx_in        = isc_pkg::CTX_RESET;
         end else begin
            held_byte_in  = req_ch.char_in;
            held_valid_in = 1'b1;
            ctx_in        = ctx_mid;
         end
      end
   end

   // shift out on pop, then append new results behind the survivors
   always_comb begin
      base = count_ff - 2'(pop);
      for (int i = 0; i < 3; i++) begin
         if (pop && i < 2) begin
            slot_in[i] = slot_ff[i + 1];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if (push_n != 2'd0 && 2'(i) == base) begin
            slot_in[i] = r0;
         end
         if (push_n == 2'd2 && 2'(i) == base + 2'd1) begin
            slot_in[i] = r1;
         end
      end
      count_in = base + push_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff  <= 8'h00;
         held_valid_ff <= 1'b0;
         ctx_ff        <= isc_pkg::CTX_RESET;
         count_ff      <= 2'd0;
      end else begin
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         ctx_ff        <= ctx_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign flush           = accept && req_ch.end_of_input;
   assign flush_with_held = flush && held_valid_ff;
   assign depth_ok        = ctx_ff.nest_depth <= isc_pkg::NEST_W'(isc_pkg::MAX_NEST);

   `ASSERT_NEXT(a_flush_two, clock, reset, flush_with_held, count_ff >= 2'd2)
   `ASSERT_NEXT(a_flush_reset, clock, reset, flush, !held_valid_ff && ctx_ff.line_count == 32'd1)
   `ASSERT_IMPLIES(a_pair_held, clock, reset, ctx_ff.pair_second, held_valid_ff)
   `ASSERT_IMPLIES(a_depth_max, clock, reset, 1'b1, depth_ok)

endmodule
